@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the text console character writer.
// Depends on nothing; every other file but tcw_ram refers to it by scoped names.
package tcw_pkg;

  // Screen geometry and tab spacing
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  // Field widths fixed by the interface
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int LIN_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 2 * CHAR_W;
  localparam int ADDR_W  = $clog2(CELLS);

  // Sweep start and end points
  localparam logic [ADDR_W-1:0] SCROLL_SRC    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] FIRST_CELL    = '0;
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);

  // Character codes and cell values
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Next tab stop for every column value the index can take
  typedef logic [2**COL_W-1:0][COL_W:0] tab_tbl_t;

  function automatic tab_tbl_t build_tab_next();
    tab_tbl_t tbl;
    for (int i = 0; i < 2**COL_W; i++) begin
      tbl[i] = (COL_W+1)'(((i + TAB_WIDTH) / TAB_WIDTH) * TAB_WIDTH);
    end
    return tbl;
  endfunction

  localparam tab_tbl_t TAB_NEXT = build_tab_next();

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH,
    ST_BLANK,
    ST_FINISH
  } tcw_state_e;

  // Controller to datapath
  typedef struct packed {
    logic              latch;
    logic              exec;
    logic              capture;
    logic              clear;
    logic              blank;
    logic              copy;
    logic              ptr_inc;
    logic              ptr_load;
    logic [ADDR_W-1:0] ptr_base;
    logic              load_result;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic do_scroll;
    logic do_ff;
    logic ptr_last;
  } tcw_sts_t;

  // Result word
  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic              scrolled;
  } tcw_res_t;

endpackage

@@ hdl/tcw_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the text console writer: valid/ready plus one request word.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::ROW_W-1:0]   read_row;
  logic [tcw_pkg::COL_W-1:0]   read_col;

  modport source (output valid, func, char_code, read_row, read_col, input ready);
  modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

@@ hdl/tcw_out_if.sv @@
`timescale 1ns / 1ps
// Output channel of the text console writer: valid/ready plus one result word.
// Depends on tcw_pkg for field widths.
interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CHAR_W-1:0]  cell_char;
  logic [tcw_pkg::CHAR_W-1:0]  cell_attr;
  logic [tcw_pkg::COL_W-1:0]   cursor_col;
  logic [tcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tcw_pkg::LIN_W-1:0]   cursor_linear;
  logic                        scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row,
                  cursor_linear, scrolled, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row,
                  cursor_linear, scrolled, output ready);
endinterface

@@ hdl/tcw_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the text console writer: clearing pass, item decode, scroll and
// blank sweeps, result hand-off. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  tcw_pkg::tcw_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_CLEAR:  if (sts_i.ptr_last) state_d = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_IDLE:   if (in_valid_i) state_d = tcw_pkg::ST_EXEC;
      tcw_pkg::ST_EXEC: begin
        if (sts_i.is_read) state_d = tcw_pkg::ST_READ;
        else if (sts_i.do_ff) state_d = tcw_pkg::ST_BLANK;
        else if (sts_i.do_scroll) state_d = tcw_pkg::ST_SCROLL;
        else state_d = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_READ:   state_d = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_SCROLL: if (sts_i.ptr_last) state_d = tcw_pkg::ST_FLUSH;
      tcw_pkg::ST_FLUSH:  state_d = tcw_pkg::ST_BLANK;
      tcw_pkg::ST_BLANK:  if (sts_i.ptr_last) state_d = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_FINISH: if (slot_free) state_d = tcw_pkg::ST_IDLE;
      default:            state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.ptr_base = tcw_pkg::FIRST_CELL;
    in_ready_o = 1'b0;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        cmd_o.clear   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      tcw_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (!sts_i.is_read && (sts_i.do_ff || sts_i.do_scroll)) begin
          cmd_o.ptr_load = 1'b1;
          cmd_o.ptr_base = sts_i.do_ff ? tcw_pkg::FIRST_CELL : tcw_pkg::SCROLL_SRC;
        end
      end
      tcw_pkg::ST_READ: cmd_o.capture = 1'b1;
      tcw_pkg::ST_SCROLL: begin
        cmd_o.copy    = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      tcw_pkg::ST_FLUSH: begin
        cmd_o.ptr_load = 1'b1;
        cmd_o.ptr_base = tcw_pkg::LAST_ROW_BASE;
      end
      tcw_pkg::ST_BLANK: begin
        cmd_o.blank   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      tcw_pkg::ST_FINISH: cmd_o.load_result = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_result) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tcw_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the text console writer: screen RAM, sweep pointer, cursor,
// attribute register and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_wdata_i,
  input  logic                       func_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::ROW_W-1:0]  read_row_i,
  input  logic [tcw_pkg::COL_W-1:0]  read_col_i,
  input  tcw_pkg::tcw_cmd_t          cmd_i,
  output tcw_pkg::tcw_sts_t          sts_o,
  output tcw_pkg::tcw_res_t          res_o
);

  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int AW = tcw_pkg::ADDR_W;

  // Latched request word
  logic                       func_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [RW-1:0]              rrow_q;
  logic [CW-1:0]              rcol_q;

  logic [tcw_pkg::CHAR_W-1:0] attr_q;
  logic [CW-1:0]              cur_x_q, cur_x_d;
  logic [RW-1:0]              cur_y_q, cur_y_d;
  logic [AW-1:0]              ptr_q, ptr_d;
  logic                       copy_pend_q;
  logic [AW-1:0]              copy_addr_q;
  logic [tcw_pkg::CHAR_W-1:0] cell_char_q, cell_attr_q;
  logic                       scrolled_q;
  tcw_pkg::tcw_res_t          res_q;

  logic [CW:0]   x_inc, tab_x;
  logic          want_nl, put_wr, do_ff, do_scroll, read_hit;
  logic [AW-1:0] cur_addr, read_addr;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign x_inc = {1'b0, cur_x_q} + (CW+1)'(1);
  assign tab_x = tcw_pkg::TAB_NEXT[cur_x_q];

  // Cursor move for the latched item
  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    want_nl   = 1'b0;
    put_wr    = 1'b0;
    do_ff     = 1'b0;
    do_scroll = 1'b0;
    if (func_q == tcw_pkg::FUNC_PUT) begin
      case (char_q)
        tcw_pkg::CH_CR: cur_x_d = '0;
        tcw_pkg::CH_LF: want_nl = 1'b1;
        tcw_pkg::CH_FF: begin
          do_ff   = 1'b1;
          cur_x_d = '0;
          cur_y_d = '0;
        end
        tcw_pkg::CH_BS: if (cur_x_q != '0) cur_x_d = cur_x_q - CW'(1);
        tcw_pkg::CH_TAB: begin
          if (tab_x >= (CW+1)'(tcw_pkg::COLUMNS)) want_nl = 1'b1;
          else cur_x_d = CW'(tab_x);
        end
        default: begin
          put_wr = 1'b1;
          if (x_inc >= (CW+1)'(tcw_pkg::COLUMNS)) want_nl = 1'b1;
          else cur_x_d = CW'(x_inc);
        end
      endcase
      if (want_nl) begin
        cur_x_d = '0;
        if (cur_y_q == RW'(tcw_pkg::ROWS - 1)) do_scroll = 1'b1;
        else cur_y_d = cur_y_q + RW'(1);
      end
    end
  end

  assign cur_addr  = AW'(AW'(cur_y_q) * AW'(tcw_pkg::COLUMNS) + AW'(cur_x_q));
  assign read_addr = AW'(AW'(rrow_q) * AW'(tcw_pkg::COLUMNS) + AW'(rcol_q));
  assign read_hit  = (32'(rrow_q) < tcw_pkg::ROWS) && (32'(rcol_q) < tcw_pkg::COLUMNS);

  assign sts_o.is_read   = (func_q == tcw_pkg::FUNC_READ);
  assign sts_o.do_scroll = do_scroll;
  assign sts_o.do_ff     = do_ff;
  assign sts_o.ptr_last  = (ptr_q == tcw_pkg::LAST_CELL);

  // Write port: clear, blank, pending copy, then the character store
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = tcw_pkg::RESET_CELL;
    if (cmd_i.clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.blank) begin
      ram_we    = 1'b1;
      ram_wdata = {attr_q, tcw_pkg::CH_SPACE};
    end else if (copy_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr_q;
      ram_wdata = ram_rdata;
    end else if (cmd_i.exec && put_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr;
      ram_wdata = {attr_q, char_q};
    end
  end

  assign ram_raddr = cmd_i.copy ? ptr_q : read_addr;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load) ptr_d = cmd_i.ptr_base;
    else if (cmd_i.ptr_inc) ptr_d = ptr_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= tcw_pkg::RESET_ATTR;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      ptr_q       <= tcw_pkg::FIRST_CELL;
      copy_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
      end
      ptr_q       <= ptr_d;
      copy_pend_q <= cmd_i.copy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    copy_addr_q <= ptr_q - tcw_pkg::SCROLL_SRC;
    if (cmd_i.exec) begin
      cell_char_q <= '0;
      cell_attr_q <= '0;
      scrolled_q  <= do_scroll;
    end else if (cmd_i.capture) begin
      cell_char_q <= read_hit ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
      cell_attr_q <= read_hit ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
    end
    if (cmd_i.load_result) begin
      res_q.cell_char     <= cell_char_q;
      res_q.cell_attr     <= cell_attr_q;
      res_q.cursor_col    <= cur_x_q;
      res_q.cursor_row    <= cur_y_q;
      res_q.cursor_linear <= tcw_pkg::LIN_W'(tcw_pkg::LIN_W'(cur_y_q) *
                             tcw_pkg::LIN_W'(tcw_pkg::COLUMNS) + tcw_pkg::LIN_W'(cur_x_q));
      res_q.scrolled      <= scrolled_q;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/text_console_char_writer.sv @@
`timescale 1ns / 1ps
// Top level of the text console character writer: 80x25 character/attribute
// screen with cursor. Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl, tcw_dp.
//
//   channel | direction | handshake     | word
//   --------+-----------+---------------+----------------------------------------
//   in_if   | sink      | valid & ready | func, char_code, read_row, read_col
//   out_if  | source    | valid & ready | cell_char, cell_attr, cursor_col/row,
//           |           |               | cursor_linear, scrolled
//   cfg     | input     | cfg_we_i      | text_attribute (8 bits)
//
// Flow: one word at a time. A put that scrolls (line feed, tab or wrap) walks the
// single screen RAM once. A form feed blanks every cell.
// Reset: a clearing pass over every cell writes blanks with attribute 7 before
// the first word is taken; config writes are taken meanwhile.
// Stalls: a finished result sits in the output register; the next word is
// accepted while it waits, and its result holds until the register frees up.
module text_console_char_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcw_in_if.sink                     in_if,
  tcw_out_if.source                  out_if,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_wdata_i
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;
  tcw_pkg::tcw_res_t res;

  // Sequencer: owns the handshakes and drives the datapath with commands
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: screen memory, cursor and result word
  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (in_if.func),
    .char_code_i (in_if.char_code),
    .read_row_i  (in_if.read_row),
    .read_col_i  (in_if.read_col),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  // Present the result word
  assign out_if.cell_char     = res.cell_char;
  assign out_if.cell_attr     = res.cell_attr;
  assign out_if.cursor_col    = res.cursor_col;
  assign out_if.cursor_row    = res.cursor_row;
  assign out_if.cursor_linear = res.cursor_linear;
  assign out_if.scrolled      = res.scrolled;

  // One word in flight: after an accept, hold off the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second word accepted while one is in flight");

  // No sweep writes while waiting for a word
  a_no_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !(cmd.copy || cmd.blank || cmd.clear))
    else $error("screen sweep active while idle");

  // Reported cursor stays on screen and its linear position agrees
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (32'(out_if.cursor_col) < tcw_pkg::COLUMNS &&
                      32'(out_if.cursor_row) < tcw_pkg::ROWS &&
                      32'(out_if.cursor_linear) ==
                      32'(out_if.cursor_row) * tcw_pkg::COLUMNS + 32'(out_if.cursor_col)))
    else $error("cursor out of range or linear position mismatch");

  // A result taken with no new load drops valid
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && !cmd.load_result) |=> !out_if.valid)
    else $error("result repeated after hand-off");

endmodule
